// ===== design/pmux_pkg.sv =====
// Package for the pin multiplexing register block.
// Holds sizes, request codes, the store interface structs and the I2C pad decode.
// No dependencies; imported by pmux_store and pin_mux_config_registers.
`timescale 1ns / 1ps

package pmux_pkg;

    // Block dimensions.
    localparam int NUM_PORTS     = 5;
    localparam int PINS_PER_PORT = 32;
    localparam int NUM_WORDS     = 2 * NUM_PORTS;
    localparam int WIDX_W        = $clog2(NUM_WORDS);
    localparam int PIDX_W        = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    // Field widths of one transaction.
    localparam int REQ_W  = 3;
    localparam int PORT_W = 3;
    localparam int PIN_W  = 5;
    localparam int MODE_W = 5;
    localparam int RD_W   = 6;

    // I2C pad setting bit pairs.
    localparam logic [3:0] I2C_HI_PAIR = 4'hA;
    localparam logic [3:0] I2C_LO_PAIR = 4'h5;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_SET_PIN   = 3'd0,
        REQ_GET_PIN   = 3'd1,
        REQ_SET_TRACE = 3'd2,
        REQ_GET_TRACE = 3'd3,
        REQ_SET_I2C   = 3'd4,
        REQ_GET_I2C   = 3'd5
    } t_req;

    // Write command from the execute stage to the store.
    typedef struct packed {
        logic              pin_wr;
        logic              trace_wr;
        logic              i2c_wr;
        logic [PORT_W-1:0] port;
        logic [PIN_W-1:0]  pin;
        logic [MODE_W-1:0] mode;
    } t_store_cmd;

    // Current settings of the addressed pin and the global fields.
    typedef struct packed {
        logic [1:0] func;
        logic [1:0] res;
        logic       od;
        logic       trace;
        logic [3:0] i2c;
    } t_store_rd;

    // Priority decode of the I2C pad setting for read back.
    function automatic logic [RD_W-1:0] i2c_decode(input logic [3:0] c);
        logic [RD_W-1:0] r;
        r = '0;
        if ((c & I2C_HI_PAIR) == 4'h0) begin
            r = r | 6'h01;
        end else if (!c[1]) begin
            r = r | 6'h04;
        end else if (!c[3]) begin
            r = r | 6'h08;
        end
        if ((c & I2C_LO_PAIR) == I2C_LO_PAIR) begin
            r = r | 6'h02;
        end else if (c[0]) begin
            r = r | 6'h10;
        end else if (c[2]) begin
            r = r | 6'h20;
        end
        return r;
    endfunction

endpackage

// ===== design/pmux_store.sv =====
// Settings store of the pin multiplexing block: function, resistor and
// open-drain words per port, trace enable and I2C pad setting.
// Depends on pmux_pkg.
`timescale 1ns / 1ps

module pmux_store
    import pmux_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr_en,
    input  t_store_cmd i_cmd,
    output t_store_rd  o_rd
);

    logic [31:0] r_func  [NUM_WORDS];
    logic [31:0] r_res   [NUM_WORDS];
    logic [31:0] r_od    [NUM_PORTS];
    logic        r_trace;
    logic [3:0]  r_i2c;

    logic              addr_ok;
    logic [WIDX_W-1:0] widx;
    logic [PIDX_W-1:0] pidx;
    logic [4:0]        sh;
    logic              func_skip;
    logic              res_skip;
    logic              od_skip;

    // Address decode: two 2-bit-per-pin words per port, one open-drain word per port.
    always_comb begin
        addr_ok   = (32'(i_cmd.port) < NUM_PORTS) && (32'(i_cmd.pin) < PINS_PER_PORT);
        widx      = WIDX_W'({i_cmd.port, i_cmd.pin[4]});
        pidx      = PIDX_W'(i_cmd.port);
        sh        = {i_cmd.pin[3:0], 1'b0};
        func_skip = (i_cmd.port == 3'd1) && (i_cmd.pin < 5'd18) && i_cmd.mode[1];
        res_skip  = (i_cmd.port == 3'd0) && (i_cmd.pin > 5'd26);
        od_skip   = (i_cmd.port == 3'd0) && ((i_cmd.pin == 5'd27) || (i_cmd.pin == 5'd28));
    end

    // Read of the addressed pin; out-of-range addresses read as zero.
    always_comb begin
        o_rd       = '0;
        o_rd.trace = r_trace;
        o_rd.i2c   = r_i2c;
        if (addr_ok) begin
            o_rd.func = r_func[widx][sh +: 2];
            o_rd.res  = r_res[widx][sh +: 2];
            o_rd.od   = r_od[pidx][i_cmd.pin];
        end
    end

    // Read-modify-write of the addressed fields; everything clears at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_func[i] <= '0;
                r_res[i]  <= '0;
            end
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_od[i] <= '0;
            end
            r_trace <= 1'b0;
            r_i2c   <= 4'h0;
        end else if (i_wr_en) begin
            if (i_cmd.pin_wr && addr_ok) begin
                if (!func_skip) begin
                    r_func[widx][sh +: 2] <= i_cmd.mode[1:0];
                end
                if (!res_skip) begin
                    r_res[widx][sh +: 2] <= i_cmd.mode[3:2];
                end
                if (!od_skip) begin
                    r_od[pidx][i_cmd.pin] <= i_cmd.mode[4];
                end
            end
            if (i_cmd.trace_wr) begin
                r_trace <= i_cmd.mode[0];
            end
            // Mode bit 0 clear drives the high pair on; bit 1 set drives the low pair on.
            if (i_cmd.i2c_wr) begin
                r_i2c <= {~i_cmd.mode[0], i_cmd.mode[1], ~i_cmd.mode[0], i_cmd.mode[1]};
            end
        end
    end

endmodule

// ===== design/pin_mux_config_registers.sv =====
// Top level of the pin multiplexing register block: input register, execute
// logic and result register around the settings store.
// Depends on pmux_pkg and pmux_store.
//
// Usage:
//   Requests arrive on i_valid / o_stall with i_req_type, i_port, i_pin and
//   i_mode; a request is taken at a clock edge where i_valid is high and
//   o_stall is low. Every request gives exactly one result on o_valid /
//   i_stall carrying o_read_data (zero for set requests, for pin reads of
//   out-of-range ports and for unused request codes).
//   A taken request waits in the input register until the result register is free
//   or being emptied; it is then executed, and its result is registered and
//   presented on o_valid from then on. Throughput is one request per cycle while
//   the receiver does not stall: each request is a single read-modify-write of the
//   addressed store fields, done between the input register and the result register.
//   Requests take effect strictly in order, so a read sees every earlier write.
//   While the receiver stalls, the result register holds; the input register
//   still takes one further request, after which o_stall is raised.
//   Reset (synchronous, active low) empties both registers and clears every
//   pin setting, the trace enable and the I2C pad setting to zero.
`timescale 1ns / 1ps

module pin_mux_config_registers
    import pmux_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [PORT_W-1:0] i_port,
    input  logic [PIN_W-1:0]  i_pin,
    input  logic [MODE_W-1:0] i_mode,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [RD_W-1:0]   o_read_data
);

    logic              r_x_valid;
    logic [REQ_W-1:0]  r_x_req;
    logic [PORT_W-1:0] r_x_port;
    logic [PIN_W-1:0]  r_x_pin;
    logic [MODE_W-1:0] r_x_mode;

    logic              r_o_valid;
    logic [RD_W-1:0]   r_o_data;

    logic              advance;
    logic              in_take;
    logic [RD_W-1:0]   n_o_data;
    t_store_cmd        cmd;
    t_store_rd         rd;

    // Handshake: execute when the result register is free or being emptied.
    assign advance = r_x_valid && (!r_o_valid || !i_stall);
    assign o_stall = r_x_valid && !advance;
    assign in_take = i_valid && !o_stall;

    // Request decode and read-back value.
    always_comb begin
        cmd          = '0;
        cmd.port     = r_x_port;
        cmd.pin      = r_x_pin;
        cmd.mode     = r_x_mode;
        n_o_data     = '0;
        unique case (t_req'(r_x_req))
            REQ_SET_PIN: begin
                cmd.pin_wr = 1'b1;
            end
            REQ_GET_PIN: begin
                n_o_data = {1'b0, rd.od, rd.res, rd.func};
            end
            REQ_SET_TRACE: begin
                cmd.trace_wr = 1'b1;
            end
            REQ_GET_TRACE: begin
                n_o_data = {{(RD_W-1){1'b0}}, rd.trace};
            end
            REQ_SET_I2C: begin
                cmd.i2c_wr = 1'b1;
            end
            REQ_GET_I2C: begin
                n_o_data = i2c_decode(rd.i2c);
            end
            default: begin
                n_o_data = '0;
            end
        endcase
    end

    pmux_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (advance),
        .i_cmd   (cmd),
        .o_rd    (rd)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
        end else if (in_take) begin
            r_x_valid <= 1'b1;
        end else if (advance) begin
            r_x_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_x_req  <= i_req_type;
            r_x_port <= i_port;
            r_x_pin  <= i_pin;
            r_x_mode <= i_mode;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_read_data = r_o_data;

    // Stall upstream only with both registers full.
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_x_valid && r_o_valid))
        else $error("stall raised with a free register");

    // An executed transaction always lands in the result register.
    a_exec_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_valid)
        else $error("executed transaction produced no result");

    // Set requests read back as zero.
    a_set_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && ((r_x_req == REQ_SET_PIN) || (r_x_req == REQ_SET_TRACE)
            || (r_x_req == REQ_SET_I2C))) |=> (o_read_data == '0))
        else $error("set request returned non-zero data");

endmodule
